// ----- rtl/odrf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Duplicate rectangle filter: shared definitions
// Sizes, the rectangle record and the compare-unit result record.
// ----------------------------------------------------------------------------
package odrf_pkg;

	// Capacity of the kept list and working coordinate width.
	localparam int unsigned MAX_KEPT   = 64;
	localparam int unsigned COORD_BITS = 12;

	// Width of the coordinate fields on the request channel.
	localparam int unsigned FIELD_W = 12;

	// Derived widths.
	localparam int unsigned IDX_W  = $clog2(MAX_KEPT);
	localparam int unsigned CNT_W  = $clog2(MAX_KEPT + 1);
	localparam int unsigned THR_W  = 8;
	localparam int unsigned AREA_W = 2 * COORD_BITS;
	localparam int unsigned PROD_W = AREA_W + THR_W;

	// Threshold after reset, about 0.80 in Q0.8.
	localparam logic [THR_W-1:0] THR_RESET = 8'd205;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t w;
		coord_t h;
	} rect_t;

	typedef struct packed {
		logic vld;
		logic dup;
	} cmp_res_t;

endpackage
`default_nettype wire

// ----- rtl/odrf_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Duplicate rectangle filter: channel interfaces
// Rectangle request channel, result channel and threshold write channel.
// ----------------------------------------------------------------------------
interface odrf_rect_if;
	logic                         valid;
	logic                         ready;
	logic                         new_set;
	logic [odrf_pkg::FIELD_W-1:0] rect_x;
	logic [odrf_pkg::FIELD_W-1:0] rect_y;
	logic [odrf_pkg::FIELD_W-1:0] rect_width;
	logic [odrf_pkg::FIELD_W-1:0] rect_height;

	modport source (output valid, new_set, rect_x, rect_y, rect_width, rect_height,
		input ready);
	modport sink (input valid, new_set, rect_x, rect_y, rect_width, rect_height,
		output ready);
endinterface

interface odrf_result_if;
	logic                       valid;
	logic                       ready;
	logic                       kept;
	logic                       list_full;
	logic [odrf_pkg::CNT_W-1:0] kept_count;

	modport source (output valid, kept, list_full, kept_count, input ready);
	modport sink (input valid, kept, list_full, kept_count, output ready);
endinterface

interface odrf_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [odrf_pkg::THR_W-1:0] overlap_threshold;

	modport source (output valid, overlap_threshold, input ready);
	modport sink (input valid, overlap_threshold, output ready);
endinterface
`default_nettype wire

// ----- rtl/odrf_cmp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Duplicate rectangle filter: overlap compare pipeline
// Four-stage test of one candidate against one stored rectangle:
// intersection * 256 > threshold * min(area_a, area_b).
// ----------------------------------------------------------------------------
module odrf_cmp (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_vld,
	input  wire odrf_pkg::rect_t            cand,
	input  wire odrf_pkg::rect_t            entry,
	input  wire logic [odrf_pkg::THR_W-1:0] thr,
	output odrf_pkg::cmp_res_t              res,
	output logic                            busy
);

	localparam int unsigned CB = odrf_pkg::COORD_BITS;
	localparam int unsigned AW = odrf_pkg::AREA_W;
	localparam int unsigned PW = odrf_pkg::PROD_W;

	// Stage 1: overlap extents in x and y, both areas.
	logic [CB-1:0] lo_x, lo_y;
	logic [CB:0]   end_ax, end_bx, end_ay, end_by, hi_x, hi_y, diff_x, diff_y;
	logic          ovl;

	always_comb begin
		lo_x   = (cand.x > entry.x) ? cand.x : entry.x;
		lo_y   = (cand.y > entry.y) ? cand.y : entry.y;
		end_ax = {1'b0, cand.x} + {1'b0, cand.w};
		end_bx = {1'b0, entry.x} + {1'b0, entry.w};
		end_ay = {1'b0, cand.y} + {1'b0, cand.h};
		end_by = {1'b0, entry.y} + {1'b0, entry.h};
		hi_x   = (end_ax < end_bx) ? end_ax : end_bx;
		hi_y   = (end_ay < end_by) ? end_ay : end_by;
		diff_x = hi_x - {1'b0, lo_x};
		diff_y = hi_y - {1'b0, lo_y};
		ovl    = (hi_x > {1'b0, lo_x}) && (hi_y > {1'b0, lo_y});
	end

	logic          vld_s1, ovl_s1;
	logic [CB-1:0] dx_s1, dy_s1;
	logic [AW-1:0] area_a_s1, area_b_s1;

	// Stage 2: intersection area and the smaller area.
	logic          vld_s2, ok_s2;
	logic [AW-1:0] inter_s2, min_s2;
	logic [AW-1:0] min_area;

	assign min_area = (area_a_s1 < area_b_s1) ? area_a_s1 : area_b_s1;

	// Stage 3: scaled threshold product.
	logic          vld_s3, ok_s3;
	logic [AW-1:0] inter_s3;
	logic [PW-1:0] prod_s3;

	// Stage 4: the verdict.
	logic          vld_s4, dup_s4;

	// Valid bits of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		ovl_s1    <= ovl;
		dx_s1     <= diff_x[CB-1:0];
		dy_s1     <= diff_y[CB-1:0];
		area_a_s1 <= AW'(cand.w) * AW'(cand.h);
		area_b_s1 <= AW'(entry.w) * AW'(entry.h);

		inter_s2  <= AW'(dx_s1) * AW'(dy_s1);
		min_s2    <= min_area;
		ok_s2     <= ovl_s1 && (min_area != '0);

		inter_s3  <= inter_s2;
		prod_s3   <= PW'(thr) * PW'(min_s2);
		ok_s3     <= ok_s2;

		dup_s4    <= ok_s3 && ({inter_s3, {odrf_pkg::THR_W{1'b0}}} > prod_s3);
	end

	assign res.vld = vld_s4;
	assign res.dup = dup_s4;
	assign busy    = vld_s1 | vld_s2 | vld_s3 | vld_s4;

`ifndef SYNTHESIS
	// A compare result follows every issued pair, after it has passed every stage register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_vld |-> ##4 res.vld)
		else $error("compare result missing four cycles after issue");

	// Zero-area pairs never report an overlap.
	a_zero_area: assert property (@(posedge clk) disable iff (!arst_n)
		(in_vld && ((cand.w == '0) || (cand.h == '0))) |-> ##4 !res.dup)
		else $error("zero-area candidate reported as duplicate");

	// A result only appears when a pair was issued and has passed every stage.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.vld) |-> $past(in_vld, 4))
		else $error("compare result without issue");
`endif

endmodule
`default_nettype wire

// ----- rtl/overlap_duplicate_rect_filter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Duplicate rectangle filter
// Greedy suppression of rectangles that overlap a rectangle kept earlier in
// the same set, measured against the smaller of the two areas.
// ----------------------------------------------------------------------------
// Usage:
//   rect    - request channel: one rectangle, with new_set to start a set.
//   result  - one result per request: kept, list_full, kept_count.
//   cfg     - threshold write channel, always ready; write only while idle.
// Timing: one request is handled at a time. A request scans the rectangles
//   stored in the set, and with an empty list or new_set it goes straight
//   to the result. The next request can be taken in the cycle the result
//   appears. The kept list sits in a memory with one write port and one
//   registered read port that is read one entry per cycle; each entry goes
//   through a four-stage compare pipeline, and the scan stops issuing reads
//   once a duplicate is found.
// Reset: the kept list is empty and the threshold is 205 (about 0.80).
//   Memory contents need no clearing; only entries below the count are read.
// Stalls: the result is held in an output register. A new request is
//   accepted while it waits, but the next result is not written until the
//   receiver has taken the previous one.
// ----------------------------------------------------------------------------
module overlap_duplicate_rect_filter (
	input  wire logic     clk,
	input  wire logic     arst_n,
	odrf_rect_if.sink     rect,
	odrf_result_if.source result,
	odrf_cfg_if.sink      cfg
);

	localparam int unsigned CB  = odrf_pkg::COORD_BITS;
	localparam int unsigned IW  = odrf_pkg::IDX_W;
	localparam int unsigned CW  = odrf_pkg::CNT_W;
	localparam logic [CW-1:0] CNT_MAX = CW'(odrf_pkg::MAX_KEPT);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]                  state_q;
	logic [CW-1:0]               cnt_q;
	logic [CW-1:0]               issue_q;
	logic                        dup_q;
	logic [odrf_pkg::THR_W-1:0]  thr_q;
	odrf_pkg::rect_t             cand_q;

	logic                        out_vld_q, kept_q, full_q;
	logic [CW-1:0]               kcount_q;

	odrf_pkg::rect_t             mem [odrf_pkg::MAX_KEPT];
	odrf_pkg::rect_t             mem_rd_q;
	logic                        rd_vld_q;

	odrf_pkg::cmp_res_t          cmp_res;
	logic                        cmp_busy;

	logic                        in_acc, rd_en, scan_end, out_free, done_fire, mem_we;
	logic [CW-1:0]               cnt_next;

	// Threshold register.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= odrf_pkg::THR_RESET;
		end else if (cfg.valid) begin
			thr_q <= cfg.overlap_threshold;
		end
	end

	// Handshake and control decode.
	assign rect.ready = (state_q == ST_IDLE);
	assign in_acc     = rect.valid && rect.ready;
	assign rd_en      = (state_q == ST_SCAN) && (issue_q < cnt_q) && !dup_q;
	assign scan_end   = (state_q == ST_SCAN) && !rd_en && !rd_vld_q && !cmp_busy;
	assign out_free   = !out_vld_q || result.ready;
	assign done_fire  = (state_q == ST_DONE) && out_free;
	assign mem_we     = done_fire && !dup_q && (cnt_q < CNT_MAX);
	assign cnt_next   = mem_we ? (cnt_q + 1'b1) : cnt_q;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			issue_q  <= '0;
			dup_q    <= 1'b0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= rd_en;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						issue_q <= '0;
						dup_q   <= 1'b0;
						if (rect.new_set) begin
							cnt_q <= '0;
						end
						state_q <= (rect.new_set || (cnt_q == '0)) ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						issue_q <= issue_q + 1'b1;
					end
					if (cmp_res.vld && cmp_res.dup) begin
						dup_q <= 1'b1;
					end
					if (scan_end) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (done_fire) begin
						cnt_q   <= cnt_next;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Candidate capture.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cand_q.x <= rect.rect_x[CB-1:0];
			cand_q.y <= rect.rect_y[CB-1:0];
			cand_q.w <= rect.rect_width[CB-1:0];
			cand_q.h <= rect.rect_height[CB-1:0];
		end
	end

	// Kept-list memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cnt_q[IW-1:0]] <= cand_q;
		end
		if (rd_en) begin
			mem_rd_q <= mem[issue_q[IW-1:0]];
		end
	end

	odrf_cmp u_cmp (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (rd_vld_q),
		.cand   (cand_q),
		.entry  (mem_rd_q),
		.thr    (thr_q),
		.res    (cmp_res),
		.busy   (cmp_busy)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (done_fire) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			kept_q   <= !dup_q;
			full_q   <= !dup_q && (cnt_q >= CNT_MAX);
			kcount_q <= cnt_next;
		end
	end

	assign result.valid      = out_vld_q;
	assign result.kept       = kept_q;
	assign result.list_full  = full_q;
	assign result.kept_count = kcount_q;

`ifndef SYNTHESIS
	// The stored count never passes the list capacity.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("kept count above capacity");

	// A full report comes only with a kept rectangle and a full list.
	a_full_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.list_full) |->
			(result.kept && (result.kept_count == CNT_MAX)))
		else $error("list_full reported without a full list");

	// No compare work is in flight while a new request can be accepted.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!rd_vld_q && !cmp_busy))
		else $error("compare pipeline busy while idle");

	// A result waiting for the receiver is not overwritten.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |=> (result.valid && $stable(kcount_q)))
		else $error("pending result lost or changed");
`endif

endmodule
`default_nettype wire
